@@ src/ftn_pkg.sv @@
// shared types and constants of the frequency table normalizer
// no dependencies; used by frequency_table_normalizer_top and ftn_div
package ftn_pkg;

  localparam int SYMBOLS  = 256;
  localparam int SYM_W    = $clog2(SYMBOLS);
  localparam int IDX_W    = $clog2(SYMBOLS + 1);
  localparam int SYMCNT_W = 9;
  localparam int CNT_W    = (IDX_W > SYMCNT_W) ? IDX_W : SYMCNT_W;
  localparam int RAW_W    = 32;
  localparam int FREQ_W   = 16;
  localparam int TOT_W    = 24;
  localparam int SCALE_W  = 17;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_REBUILD = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       symbol;
    logic [RAW_W-1:0] raw_count;
  } in_t;

  typedef struct packed {
    logic [FREQ_W-1:0] sym_freq;
    logic [TOT_W-1:0]  low_total;
    logic [TOT_W-1:0]  high_total;
    logic [TOT_W-1:0]  grand_total;
  } out_t;

endpackage

@@ src/frequency_table_normalizer_top.sv @@
// top level of the frequency table normalizer: control sequencer and stores
// depends on ftn_pkg, ftn_ram and ftn_div
//
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one item at a time:
//   load writes a raw count, rebuild recomputes the scaled totals, query
//   reads one symbol's totals. every item yields exactly one result item on
//   the out channel (out_valid_o/out_ready_i/out_data_o).
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes symbol_count,
//   always ready; write it only while the block is idle.
//   a load result goes into the output register on acceptance; a query
//   issues the total ram read on acceptance and emits the registered read
//   data from S_QRD. a rebuild scans the count ram for the maximum (S_MAX),
//   then per symbol reads the count (S_RD, S_DST), divides it (S_DIV) and
//   accumulates (S_ACC); symbols at or past symbol_count skip the divider.
//   the next item is accepted once the previous one has left the sequencer,
//   even while its result still waits in the output register.
//   reset: counts read as zero (per-entry valid bits), totals read as zero
//   until the first rebuild, symbol_count is 256. no clearing pass.
//   a stalled receiver holds the output register; the sequencer parks its
//   next result until the register frees up.
module frequency_table_normalizer_top
  import ftn_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ftn_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ftn_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ftn_pkg::SYMCNT_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUT,
    S_QRD,
    S_MAX,
    S_SCALE,
    S_RD,
    S_DST,
    S_DIV,
    S_ACC
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [RAW_W-1:0]    max_q, max_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [TOT_W-1:0]    run_q, run_d;
  logic [TOT_W-1:0]    grand_q, grand_d;
  logic                built_q, built_d;
  logic [FREQ_W-1:0]   sf_q, sf_d;
  logic                cnt_nz_q, cnt_nz_d;
  logic                rd_v_q, rd_v_d;
  logic                oor_q, oor_d;
  logic                cnt_hit_q;
  out_t                res_q, res_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [SYMCNT_W-1:0] symcnt_q, symcnt_d;
  logic [SYMBOLS-1:0]  cnt_vld_q, cnt_vld_d;

  logic                cnt_we;
  logic [SYM_W-1:0]    cnt_waddr;
  logic [SYM_W-1:0]    cnt_raddr;
  logic [RAW_W-1:0]    cnt_rdata;
  logic [RAW_W-1:0]    cnt_val;
  logic                tot_we;
  logic [SYM_W-1:0]    tot_waddr;
  logic [2*TOT_W-1:0]  tot_wdata;
  logic [SYM_W-1:0]    tot_raddr;
  logic [2*TOT_W-1:0]  tot_rdata;

  logic                div_start;
  logic                div_done;
  logic [FREQ_W-1:0]   div_quo;

  logic [CNT_W-1:0]    n_act;
  logic                idx_act;
  logic                sym_in;
  logic                slot_free;
  logic                emit;
  out_t                emit_res;
  logic [TOT_W:0]      sum;
  logic [TOT_W-1:0]    run_new;
  logic [TOT_W-1:0]    q_lo, q_hi;

  ftn_ram #(.WIDTH(RAW_W), .DEPTH(SYMBOLS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (in_data_i.raw_count),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // entry i holds the low and high totals of symbol i
  ftn_ram #(.WIDTH(2*TOT_W), .DEPTH(SYMBOLS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  ftn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cnt_val),
    .divisor_i  (scale_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign n_act = (CNT_W'(symcnt_q) > CNT_W'(SYMBOLS)) ? CNT_W'(SYMBOLS) : CNT_W'(symcnt_q);
  assign idx_act   = CNT_W'(idx_q) < n_act;
  assign sym_in    = 32'(in_data_i.symbol) < 32'(SYMBOLS);
  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_raddr = idx_q[SYM_W-1:0];
  assign cnt_val   = cnt_hit_q ? cnt_rdata : '0;
  assign tot_raddr = SYM_W'(in_data_i.symbol);
  assign tot_waddr = idx_q[SYM_W-1:0];
  assign tot_wdata = {run_q, run_new};
  assign cnt_waddr = SYM_W'(in_data_i.symbol);

  // saturating running total
  assign sum     = {1'b0, run_q} + (TOT_W + 1)'(sf_q);
  assign run_new = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];

  always_comb begin
    q_lo = built_q ? tot_rdata[2*TOT_W-1:TOT_W] : '0;
    q_hi = built_q ? tot_rdata[TOT_W-1:0] : '0;
    if (oor_q) begin
      q_lo = grand_q;
      q_hi = grand_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    max_d       = max_q;
    scale_d     = scale_q;
    run_d       = run_q;
    grand_d     = grand_q;
    built_d     = built_q;
    sf_d        = sf_q;
    cnt_nz_d    = cnt_nz_q;
    rd_v_d      = 1'b0;
    oor_d       = oor_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    symcnt_d    = symcnt_q;
    cnt_vld_d   = cnt_vld_q;
    cnt_we      = 1'b0;
    tot_we      = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_res    = '0;

    if (cfg_valid_i) begin
      symcnt_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(in_data_i.op))
            OP_LOAD: begin
              if (sym_in) begin
                cnt_we = 1'b1;
                cnt_vld_d[cnt_waddr] = 1'b1;
              end
              emit = 1'b1;
            end
            OP_REBUILD: begin
              idx_d   = '0;
              max_d   = '0;
              state_d = S_MAX;
            end
            OP_QUERY: begin
              oor_d   = !sym_in;
              state_d = S_QRD;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_QRD: begin
        emit                 = 1'b1;
        emit_res.sym_freq    = FREQ_W'(q_hi - q_lo);
        emit_res.low_total   = q_lo;
        emit_res.high_total  = q_hi;
        emit_res.grand_total = grand_q;
      end
      S_MAX: begin
        // read issued this cycle, compared the next
        rd_v_d = idx_act && (idx_q != IDX_W'(SYMBOLS));
        if (rd_v_q && cnt_val > max_q) begin
          max_d = cnt_val;
        end
        if (idx_q == IDX_W'(SYMBOLS)) begin
          state_d = S_SCALE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCALE: begin
        scale_d = {1'b0, max_q[RAW_W-1:FREQ_W]} + SCALE_W'(1);
        idx_d   = '0;
        run_d   = '0;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_DST;
      end
      S_DST: begin
        if (idx_act) begin
          div_start = 1'b1;
          cnt_nz_d  = cnt_val != '0;
          state_d   = S_DIV;
        end else begin
          sf_d    = '0;
          state_d = S_ACC;
        end
      end
      S_DIV: begin
        if (div_done) begin
          // a nonzero count never scales to zero
          sf_d    = (div_quo == '0 && cnt_nz_q) ? FREQ_W'(1) : div_quo;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        tot_we = 1'b1;
        run_d  = run_new;
        if (idx_q == IDX_W'(SYMBOLS - 1)) begin
          grand_d              = run_new;
          built_d              = 1'b1;
          emit                 = 1'b1;
          emit_res.grand_total = run_new;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      if (slot_free) begin
        out_d       = emit_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = emit_res;
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      max_q       <= '0;
      scale_q     <= '0;
      run_q       <= '0;
      grand_q     <= '0;
      built_q     <= 1'b0;
      sf_q        <= '0;
      cnt_nz_q    <= 1'b0;
      rd_v_q      <= 1'b0;
      oor_q       <= 1'b0;
      cnt_hit_q   <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      symcnt_q    <= SYMCNT_W'(256);
      cnt_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      max_q       <= max_d;
      scale_q     <= scale_d;
      run_q       <= run_d;
      grand_q     <= grand_d;
      built_q     <= built_d;
      sf_q        <= sf_d;
      cnt_nz_q    <= cnt_nz_d;
      rd_v_q      <= rd_v_d;
      oor_q       <= oor_d;
      cnt_hit_q   <= cnt_vld_q[cnt_raddr];
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      symcnt_q    <= symcnt_d;
      cnt_vld_q   <= cnt_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_parked_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> out_valid_q)
    else $error("result parked while output register is empty");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");
  a_built_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> $past(state_q) == S_ACC)
    else $error("table marked built without a finished rebuild");
  a_scan_in_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> state_q == S_MAX)
    else $error("count scan data outside the maximum pass");

endmodule

@@ src/ftn_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no package dependencies
module ftn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ftn_div.sv @@
// iterative divider, four quotient bits per cycle, 16-bit quotient
// depends on ftn_pkg; caller guarantees dividend < 65536 * divisor
module ftn_div
  import ftn_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ftn_pkg::RAW_W-1:0]   dividend_i,
  input  logic [ftn_pkg::SCALE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ftn_pkg::FREQ_W-1:0]  quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [1:0]         step_q, step_d;
  logic [SCALE_W-1:0] rem_q, rem_d;
  logic [SCALE_W-1:0] dvs_q, dvs_d;
  logic [FREQ_W-1:0]  dvd_q, dvd_d;
  logic [FREQ_W-1:0]  quo_q, quo_d;

  logic [SCALE_W-1:0] r;
  logic [SCALE_W:0]   t;
  logic [3:0]         qb;

  // four restoring steps on the partial remainder
  always_comb begin
    r  = rem_q;
    qb = '0;
    for (int k = 0; k < 4; k++) begin
      t = {r, dvd_q[FREQ_W-1-k]};
      if (t >= {1'b0, dvs_q}) begin
        r         = SCALE_W'(t - {1'b0, dvs_q});
        qb[3-k]   = 1'b1;
      end else begin
        r = t[SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {1'b0, dividend_i[RAW_W-1:FREQ_W]};
      dvd_d  = dividend_i[FREQ_W-1:0];
      dvs_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = r;
      dvd_d  = {dvd_q[FREQ_W-5:0], 4'b0000};
      quo_d  = {quo_q[FREQ_W-5:0], qb};
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      dvd_q  <= dvd_d;
      quo_q  <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("divider remainder out of range");

endmodule
